FILE: design/keypad_four_function_calculator_core_defines.svh
// Assertion macros shared by the calculator RTL.
`ifndef KEYPAD_FOUR_FUNCTION_CALCULATOR_CORE_DEFINES_SVH
`define KEYPAD_FOUR_FUNCTION_CALCULATOR_CORE_DEFINES_SVH

// The condition holding at an edge implies the consequent at the same edge.
`define KFFC_ASSERT_NOW(label, cond, consequent, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (consequent)) \
    else $error(msg);

// The condition holding at an edge implies the consequent at the next edge.
`define KFFC_ASSERT_NEXT(label, cond, consequent, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (consequent)) \
    else $error(msg);

`endif

FILE: design/kffc_pkg.sv
// Shared types, key codes and defaults for the keypad calculator.
package kffc_pkg;

  localparam int OPERAND_BITS_DEF  = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int MAG_BITS          = 64;
  localparam int FRAC_OUT_BITS     = 16;

  localparam logic [7:0] KEY_NONE = 8'd0;
  localparam logic [7:0] KEY_ADD  = 8'd43;
  localparam logic [7:0] KEY_SUB  = 8'd45;
  localparam logic [7:0] KEY_MUL  = 8'd42;
  localparam logic [7:0] KEY_DIV  = 8'd47;
  localparam logic [7:0] KEY_EQ   = 8'd61;
  localparam logic [7:0] KEY_CLR  = 8'd46;
  localparam logic [7:0] KEY_ZERO = 8'd48;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_NOOP = 2'd2
  } status_t;

  typedef struct packed {
    logic                     negative;
    logic [MAG_BITS-1:0]      magnitude;
    logic [FRAC_OUT_BITS-1:0] fraction;
    status_t                  status;
  } res_t;

endpackage

FILE: design/kffc_alu.sv
// Iterative arithmetic unit built around one shared adder.
module kffc_alu #(
  parameter int OPERAND_BITS  = kffc_pkg::OPERAND_BITS_DEF,
  parameter int FRACTION_BITS = kffc_pkg::FRACTION_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  kffc_pkg::op_t           op,
  input  logic [OPERAND_BITS-1:0] a,
  input  logic [OPERAND_BITS-1:0] b,
  output logic                    done,
  output kffc_pkg::res_t          res
);

  localparam int N  = OPERAND_BITS;
  localparam int QW = OPERAND_BITS + FRACTION_BITS;
  localparam int CW = $clog2(QW);
  localparam logic [kffc_pkg::FRAC_OUT_BITS-1:0] FRAC_MASK =
    kffc_pkg::FRAC_OUT_BITS'((32'd1 << FRACTION_BITS) - 32'd1);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_SUB2 = 5'b00010,
    A_MUL  = 5'b00100,
    A_DIV  = 5'b01000,
    A_DONE = 5'b10000
  } alu_state_t;

  alu_state_t      state;
  logic [CW-1:0]   cnt;
  logic [N-1:0]    areg;
  logic [N-1:0]    breg;
  logic [N-1:0]    hi;
  logic [N-1:0]    lo;
  logic [N-1:0]    rem;
  logic [QW-1:0]   dvd;

  logic [N:0]      opx;
  logic [N:0]      opy;
  logic            cin;
  logic [N+1:0]    sum;
  logic [N:0]      shifted;
  logic            q_bit;
  logic [N-1:0]    rem_next;
  logic [QW-1:0]   dvd_next;
  logic [N-1:0]    hi_next;
  logic [N-1:0]    lo_next;

  assign shifted = {rem, dvd[QW-1]};

  always_comb begin
    opx = '0;
    opy = '0;
    cin = 1'b0;
    unique case (state)
      A_IDLE: begin
        opx = {1'b0, a};
        if (op == kffc_pkg::OP_SUB) begin
          opy = ~{1'b0, b};
          cin = 1'b1;
        end else begin
          opy = {1'b0, b};
        end
      end
      A_SUB2: begin
        opx = {1'b0, breg};
        opy = ~{1'b0, areg};
        cin = 1'b1;
      end
      A_MUL: begin
        opx = {1'b0, hi};
        opy = lo[0] ? {1'b0, breg} : '0;
      end
      A_DIV: begin
        opx = shifted;
        opy = ~{1'b0, breg};
        cin = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign sum      = {1'b0, opx} + {1'b0, opy} + {{(N + 1){1'b0}}, cin};
  assign q_bit    = sum[N+1];
  assign rem_next = q_bit ? sum[N-1:0] : shifted[N-1:0];
  assign dvd_next = {dvd[QW-2:0], q_bit};
  assign hi_next  = sum[N:1];
  assign lo_next  = {sum[0], lo[N-1:1]};
  assign done     = (state == A_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (start) begin
            areg             <= a;
            breg             <= b;
            cnt              <= '0;
            res.negative     <= 1'b0;
            res.fraction     <= '0;
            unique case (op)
              kffc_pkg::OP_ADD: begin
                res.status    <= kffc_pkg::ST_OK;
                res.magnitude <= kffc_pkg::MAG_BITS'(sum[N:0]);
                state         <= A_DONE;
              end
              kffc_pkg::OP_SUB: begin
                res.status    <= kffc_pkg::ST_OK;
                res.magnitude <= kffc_pkg::MAG_BITS'(sum[N-1:0]);
                state         <= sum[N] ? A_SUB2 : A_DONE;
              end
              kffc_pkg::OP_MUL: begin
                res.status <= kffc_pkg::ST_OK;
                hi         <= '0;
                lo         <= a;
                state      <= A_MUL;
              end
              kffc_pkg::OP_DIV: begin
                if (b == '0) begin
                  res.status    <= kffc_pkg::ST_DIV0;
                  res.magnitude <= '0;
                  state         <= A_DONE;
                end else begin
                  res.status <= kffc_pkg::ST_OK;
                  rem        <= '0;
                  dvd        <= QW'(a) << FRACTION_BITS;
                  state      <= A_DIV;
                end
              end
              default: begin
                res.status    <= kffc_pkg::ST_NOOP;
                res.magnitude <= '0;
                state         <= A_DONE;
              end
            endcase
          end
        end
        A_SUB2: begin
          res.negative  <= 1'b1;
          res.magnitude <= kffc_pkg::MAG_BITS'(sum[N-1:0]);
          state         <= A_DONE;
        end
        A_MUL: begin
          hi  <= hi_next;
          lo  <= lo_next;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(N - 1)) begin
            res.magnitude <= kffc_pkg::MAG_BITS'({hi_next, lo_next});
            state         <= A_DONE;
          end
        end
        A_DIV: begin
          rem <= rem_next;
          dvd <= dvd_next;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(QW - 1)) begin
            res.magnitude <= kffc_pkg::MAG_BITS'(dvd_next[QW-1:FRACTION_BITS]);
            res.fraction  <= kffc_pkg::FRAC_OUT_BITS'(dvd_next) & FRAC_MASK;
            state         <= A_DONE;
          end
        end
        A_DONE: begin
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/keypad_four_function_calculator_core.sv
// Top level of the keypad calculator: key decoding, operand entry and result request.
// Digit, operator, clear and idle keys: one key every cycle in T_IDLE, stalled by in_stall otherwise.
// After '=' add and subtract take one adder step, a negative difference two, multiply
// OPERAND_BITS and divide OPERAND_BITS+FRACTION_BITS steps (one adder step a cycle).
// Synchronous rst clears both operands, the pending operation and any waiting result.
module keypad_four_function_calculator_core #(
  parameter int OPERAND_BITS  = kffc_pkg::OPERAND_BITS_DEF,
  parameter int FRACTION_BITS = kffc_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        negative,
  output logic [63:0] magnitude,
  output logic [15:0] fraction,
  output logic [1:0]  status
);

`include "keypad_four_function_calculator_core_defines.svh"

  localparam int N = OPERAND_BITS;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_CALC = 3'b010,
    T_OUT  = 3'b100
  } top_state_t;

  top_state_t     state;
  logic [N-1:0]   first_operand;
  logic [N-1:0]   second_operand;
  kffc_pkg::op_t  pending_operation;
  logic           entering_second;

  logic           accept;
  logic           alu_start;
  logic           alu_done;
  kffc_pkg::res_t alu_res;
  logic [N-1:0]   digit_src;
  logic [N-1:0]   folded;

  assign in_stall  = (state != T_IDLE);
  assign accept    = in_valid && !in_stall;
  assign alu_start = accept && (key == kffc_pkg::KEY_EQ);
  assign out_valid = (state == T_OUT);

  assign digit_src = entering_second ? second_operand : first_operand;
  assign folded    = (digit_src << 3) + (digit_src << 1) + N'(key) - N'(kffc_pkg::KEY_ZERO);

  kffc_alu #(
    .OPERAND_BITS  (OPERAND_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .op    (pending_operation),
    .a     (first_operand),
    .b     (second_operand),
    .done  (alu_done),
    .res   (alu_res)
  );

  assign negative  = alu_res.negative;
  assign magnitude = alu_res.magnitude;
  assign fraction  = alu_res.fraction;
  assign status    = alu_res.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= T_IDLE;
      first_operand     <= '0;
      second_operand    <= '0;
      pending_operation <= kffc_pkg::OP_NONE;
      entering_second   <= 1'b0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            unique case (key)
              kffc_pkg::KEY_NONE: begin
              end
              kffc_pkg::KEY_ADD: begin
                pending_operation <= kffc_pkg::OP_ADD;
                entering_second   <= 1'b1;
              end
              kffc_pkg::KEY_SUB: begin
                pending_operation <= kffc_pkg::OP_SUB;
                entering_second   <= 1'b1;
              end
              kffc_pkg::KEY_MUL: begin
                pending_operation <= kffc_pkg::OP_MUL;
                entering_second   <= 1'b1;
              end
              kffc_pkg::KEY_DIV: begin
                pending_operation <= kffc_pkg::OP_DIV;
                entering_second   <= 1'b1;
              end
              kffc_pkg::KEY_CLR: begin
                first_operand     <= '0;
                second_operand    <= '0;
                pending_operation <= kffc_pkg::OP_NONE;
                entering_second   <= 1'b0;
              end
              kffc_pkg::KEY_EQ: begin
                first_operand     <= '0;
                second_operand    <= '0;
                pending_operation <= kffc_pkg::OP_NONE;
                entering_second   <= 1'b0;
                state             <= T_CALC;
              end
              default: begin
                if (entering_second) begin
                  second_operand <= folded;
                end else begin
                  first_operand <= folded;
                end
              end
            endcase
          end
        end
        T_CALC: begin
          if (alu_done) begin
            state <= T_OUT;
          end
        end
        T_OUT: begin
          if (!out_stall) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  `KFFC_ASSERT_NOW(a_no_key_while_result, out_valid, in_stall, "Key taken while a result waits.")
  `KFFC_ASSERT_NOW(a_done_only_in_calc, alu_done, state == T_CALC, "Unit finished outside a request.")
  `KFFC_ASSERT_NEXT(a_clear_after_equals, alu_start, first_operand == '0 && second_operand == '0 && pending_operation == kffc_pkg::OP_NONE && !entering_second, "State not cleared after equals.")

endmodule
